// ===== rtl/irmag_pkg.sv =====
// Shared constants and types for the image rotate/mirror address generator.
`default_nettype none

package irmag_pkg;

  localparam int unsigned MAX_DIM_DEF     = 4096;
  localparam int unsigned PITCH_ALIGN_DEF = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned ORIENT_W = 3;
  localparam int unsigned DIMREG_W = 13;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned SPITCH_W = 16;
  localparam int unsigned ADDR_W   = 32;

  localparam logic [BPP_W-1:0]    BPP_THREE     = 3'd3;
  localparam logic [BPP_W-1:0]    BPP_FOUR      = 3'd4;
  localparam logic [SPITCH_W-1:0] SPITCH_RESET  = 16'd16;
  localparam logic [DIMREG_W-1:0] DIM_RESET     = 13'd1;

  typedef enum logic [IDX_W-1:0] {
    REG_ORIENTATION  = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_BPP          = 3'd3,
    REG_SRC_PITCH    = 3'd4,
    REG_SRC_BASE     = 3'd5,
    REG_DST_BASE     = 3'd6,
    REG_NONE         = 3'd7
  } reg_idx_e;

  typedef enum logic [ORIENT_W-1:0] {
    OR_IDENT      = 3'd0,
    OR_MIRROR     = 3'd1,
    OR_ROT90      = 3'd2,
    OR_ROT90_MIR  = 3'd3,
    OR_ROT180     = 3'd4,
    OR_ROT180_MIR = 3'd5,
    OR_ROT270     = 3'd6,
    OR_ROT270_MIR = 3'd7
  } orient_e;

endpackage

`default_nettype wire

// ===== rtl/irmag_pitch.sv =====
// Destination row pitch: dest width times bytes per pixel, rounded up to the alignment.
`default_nettype none

module irmag_pitch #(
  parameter int unsigned MAX_DIM     = irmag_pkg::MAX_DIM_DEF,
  parameter int unsigned PITCH_ALIGN = irmag_pkg::PITCH_ALIGN_DEF,
  parameter int unsigned DIM_W       = $clog2(MAX_DIM + 1),
  parameter int unsigned PV_W        = DIM_W + 4
) (
  input  wire logic             clk_i,
  input  wire logic [DIM_W-1:0] dest_width_i,
  input  wire logic             bpp_three_i,
  output logic      [PV_W-1:0]  pitch_o
);

  localparam int unsigned AL_W  = $clog2(PITCH_ALIGN + 1);
  localparam int unsigned SH    = PV_W + AL_W;
  localparam int unsigned RC_W  = SH + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(PITCH_ALIGN) - 64'd1) / 64'(PITCH_ALIGN);
  localparam logic [RC_W-1:0] RECIP_V = RC_W'(RECIP);
  localparam logic [PV_W-1:0] ALIGN_V = PV_W'(PITCH_ALIGN);
  localparam logic [PV_W-1:0] ALIGN_M1 = PV_W'(PITCH_ALIGN - 1);

  logic [PV_W-1:0]      bytes_w;
  logic [PV_W-1:0]      padded;
  logic [PV_W+RC_W-1:0] prod;
  logic [PV_W-1:0]      quo_d;
  logic [PV_W-1:0]      quo_q;
  logic [PV_W-1:0]      pitch_d;
  logic [PV_W-1:0]      pitch_q;

  always_comb begin
    bytes_w = PV_W'(dest_width_i) * (bpp_three_i ? PV_W'(3) : PV_W'(4));
    padded  = bytes_w + ALIGN_M1;
    prod    = (PV_W+RC_W)'(padded) * (PV_W+RC_W)'(RECIP_V);
    quo_d   = PV_W'(prod >> SH);
    pitch_d = PV_W'(quo_q * ALIGN_V);
  end

  // follows the configuration registers through the quotient and pitch registers
  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    pitch_q <= pitch_d;
  end

  assign pitch_o = pitch_q;

endmodule

`default_nettype wire

// ===== rtl/image_rotate_mirror_address_gen_unit.sv =====
// Top level: config registers, raster walk and four-stage address pipeline.
//
// One word in, one source/destination address pair out, every clock while the
// output is not stalled. The raster position is updated at input acceptance;
// the addresses come out through a pipeline of position, products, source sum
// and destination sum stages, each with its own valid bit, so a stall on the
// output only backs up as far as the pipeline is full. The destination pitch
// is recomputed from the registers continuously, through a quotient register
// and a pitch register.
`default_nettype none

module image_rotate_mirror_address_gen_unit #(
  parameter int unsigned MAX_DIM     = irmag_pkg::MAX_DIM_DEF,
  parameter int unsigned PITCH_ALIGN = irmag_pkg::PITCH_ALIGN_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [irmag_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [irmag_pkg::DATA_W-1:0]       pwdata,
  output logic      [irmag_pkg::DATA_W-1:0]       prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               restart_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [irmag_pkg::ADDR_W-1:0]       source_address_o,
  output logic      [irmag_pkg::ADDR_W-1:0]       destination_address_o,
  output logic                                    row_end_o,
  output logic                                    last_pixel_o
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned POS_W = $clog2(MAX_DIM);
  localparam int unsigned PV_W  = DIM_W + 4;
  localparam int unsigned AW    = irmag_pkg::ADDR_W;

  // configuration registers
  irmag_pkg::orient_e                orient_q;
  logic [irmag_pkg::DIMREG_W-1:0]    width_q;
  logic [irmag_pkg::DIMREG_W-1:0]    height_q;
  logic [irmag_pkg::BPP_W-1:0]       bpp_q;
  logic [irmag_pkg::SPITCH_W-1:0]    spitch_q;
  logic [AW-1:0]                     sbase_q;
  logic [AW-1:0]                     dbase_q;

  irmag_pkg::reg_idx_e reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = irmag_pkg::reg_idx_e'(paddr[irmag_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= irmag_pkg::OR_IDENT;
      width_q  <= irmag_pkg::DIM_RESET;
      height_q <= irmag_pkg::DIM_RESET;
      bpp_q    <= irmag_pkg::BPP_FOUR;
      spitch_q <= irmag_pkg::SPITCH_RESET;
      sbase_q  <= '0;
      dbase_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        irmag_pkg::REG_ORIENTATION:  orient_q <= irmag_pkg::orient_e'(pwdata[2:0]);
        irmag_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[irmag_pkg::DIMREG_W-1:0];
        irmag_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[irmag_pkg::DIMREG_W-1:0];
        irmag_pkg::REG_BPP:          bpp_q    <= pwdata[irmag_pkg::BPP_W-1:0];
        irmag_pkg::REG_SRC_PITCH:    spitch_q <= pwdata[irmag_pkg::SPITCH_W-1:0];
        irmag_pkg::REG_SRC_BASE:     sbase_q  <= pwdata;
        irmag_pkg::REG_DST_BASE:     dbase_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      irmag_pkg::REG_ORIENTATION:  prdata = 32'(orient_q);
      irmag_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_q);
      irmag_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_q);
      irmag_pkg::REG_BPP:          prdata = 32'(bpp_q);
      irmag_pkg::REG_SRC_PITCH:    prdata = 32'(spitch_q);
      irmag_pkg::REG_SRC_BASE:     prdata = sbase_q;
      irmag_pkg::REG_DST_BASE:     prdata = dbase_q;
      default:                     prdata = '0;
    endcase
  end

  // clamped geometry
  logic [DIM_W-1:0] wc;
  logic [DIM_W-1:0] hc;
  logic [DIM_W-1:0] dw;
  logic             bpp_three;
  logic [2:0]       bval;
  logic [PV_W-1:0]  dpitch;

  always_comb begin
    if (width_q == '0)
      wc = DIM_W'(1);
    else if (32'(width_q) > 32'(MAX_DIM))
      wc = DIM_W'(MAX_DIM);
    else
      wc = DIM_W'(width_q);
    if (height_q == '0)
      hc = DIM_W'(1);
    else if (32'(height_q) > 32'(MAX_DIM))
      hc = DIM_W'(MAX_DIM);
    else
      hc = DIM_W'(height_q);
    bpp_three = (bpp_q == irmag_pkg::BPP_THREE);
    bval      = bpp_three ? irmag_pkg::BPP_THREE : irmag_pkg::BPP_FOUR;
    dw        = orient_q[1] ? hc : wc;
  end

  irmag_pitch #(
    .MAX_DIM     (MAX_DIM),
    .PITCH_ALIGN (PITCH_ALIGN),
    .DIM_W       (DIM_W),
    .PV_W        (PV_W)
  ) u_pitch (
    .clk_i        (clk_i),
    .dest_width_i (dw),
    .bpp_three_i  (bpp_three),
    .pitch_o      (dpitch)
  );

  // pipeline flow control
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic in_acc;

  assign en4        = !v4_q || !out_stall_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;
  assign in_acc     = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // raster walk
  logic [POS_W-1:0] col_q, row_q;
  logic [POS_W-1:0] col_d, row_d;
  logic [POS_W-1:0] x, y;
  logic             rend, last;

  always_comb begin
    if (restart_i || DIM_W'(col_q) >= wc || DIM_W'(row_q) >= hc) begin
      x = '0;
      y = '0;
    end else begin
      x = col_q;
      y = row_q;
    end
    rend = (DIM_W'(x) == wc - DIM_W'(1));
    last = rend && (DIM_W'(y) == hc - DIM_W'(1));
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (rend) begin
      col_d = '0;
      row_d = y + POS_W'(1);
    end else begin
      col_d = x + POS_W'(1);
      row_d = y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: position
  logic [POS_W-1:0] x1_q, y1_q;
  logic             rend1_q, last1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q    <= x;
      y1_q    <= y;
      rend1_q <= rend;
      last1_q <= last;
    end
  end

  // stage 2: destination coordinates and products
  logic [POS_W-1:0] xr, yr, dc, dr;
  logic [AW-1:0]    dr2_q, yp2_q, xb2_q, dcb2_q;
  logic             rend2_q, last2_q;

  always_comb begin
    xr = POS_W'(wc - DIM_W'(1) - DIM_W'(x1_q));
    yr = POS_W'(hc - DIM_W'(1) - DIM_W'(y1_q));
    unique case (orient_q)
      irmag_pkg::OR_MIRROR:     begin dc = xr;   dr = y1_q; end
      irmag_pkg::OR_ROT90:      begin dc = yr;   dr = x1_q; end
      irmag_pkg::OR_ROT90_MIR:  begin dc = yr;   dr = xr;   end
      irmag_pkg::OR_ROT180:     begin dc = xr;   dr = yr;   end
      irmag_pkg::OR_ROT180_MIR: begin dc = x1_q; dr = yr;   end
      irmag_pkg::OR_ROT270:     begin dc = y1_q; dr = xr;   end
      irmag_pkg::OR_ROT270_MIR: begin dc = y1_q; dr = x1_q; end
      default:                  begin dc = x1_q; dr = y1_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      dr2_q   <= AW'(dr);
      yp2_q   <= AW'(y1_q) * AW'(spitch_q);
      xb2_q   <= AW'(x1_q) * AW'(bval);
      dcb2_q  <= AW'(dc) * AW'(bval);
      rend2_q <= rend1_q;
      last2_q <= last1_q;
    end
  end

  // stage 3: source sum and destination row product
  logic [AW-1:0] src3_q, drp3_q, dcb3_q;
  logic          rend3_q, last3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      src3_q  <= sbase_q + yp2_q + xb2_q;
      drp3_q  <= dr2_q * AW'(dpitch);
      dcb3_q  <= dcb2_q;
      rend3_q <= rend2_q;
      last3_q <= last2_q;
    end
  end

  // stage 4: output register
  logic [AW-1:0] src4_q, dst4_q;
  logic          rend4_q, last4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      src4_q  <= src3_q;
      dst4_q  <= (orient_q == irmag_pkg::OR_IDENT) ? src3_q : dbase_q + drp3_q + dcb3_q;
      rend4_q <= rend3_q;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o           = v4_q;
  assign source_address_o      = src4_q;
  assign destination_address_o = dst4_q;
  assign row_end_o             = rend4_q;
  assign last_pixel_o          = last4_q;

  // checks
  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!last_pixel_o || row_end_o))
    else $error("last pixel without row end");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a bubble in the pipeline");

  // a restart or an out-of-image position starts over at row 0, so row 1 may follow
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (row_q == '0 || row_q == POS_W'(1) || row_q == $past(row_q) ||
                row_q == $past(row_q) + POS_W'(1)))
    else $error("row counter jumped");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the image rotate/mirror address generator: directed table, random walks, scoreboard.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIMREG_W = irmag_pkg::DIMREG_W;
  localparam int unsigned BPP_W    = irmag_pkg::BPP_W;
  localparam int unsigned SPITCH_W = irmag_pkg::SPITCH_W;
  localparam int unsigned ADDR_W   = irmag_pkg::ADDR_W;
  localparam int unsigned DATA_W   = irmag_pkg::DATA_W;
  localparam int unsigned PADDR_W  = irmag_pkg::PADDR_W;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned PHASE_WORDS = 267;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic        rend;
    logic        last;
  } pix_addr_t;

  typedef struct packed {
    irmag_pkg::orient_e   orient;
    logic [DIMREG_W-1:0]  width;
    logic [DIMREG_W-1:0]  height;
    logic [BPP_W-1:0]     bpp;
    logic [SPITCH_W-1:0]  spitch;
    logic [ADDR_W-1:0]    sbase;
    logic [ADDR_W-1:0]    dbase;
  } cfg_set_t;

  typedef struct packed {
    bit          wr_cfg;
    cfg_set_t    cfg;
    bit          restart;
    int unsigned count;
    bit          typed;
    pix_addr_t   want;
  } dir_row_t;

  localparam pix_addr_t NO_WANT   = '0;
  localparam pix_addr_t ONE_PIXEL = '{32'h0, 32'h0, 1'b1, 1'b1};
  localparam cfg_set_t  CFG_RESET = '{irmag_pkg::OR_IDENT, irmag_pkg::DIM_RESET,
                                      irmag_pkg::DIM_RESET, irmag_pkg::BPP_FOUR,
                                      irmag_pkg::SPITCH_RESET, 32'h0, 32'h0};

  // restart/wrap on reset config, degenerate sizes, max sizes, each orientation,
  // position outside a shrunk image, identity with a padded source pitch
  localparam dir_row_t DIR_ROWS [10] = '{
    '{1'b0, CFG_RESET, 1'b1, 1, 1'b1, ONE_PIXEL},
    '{1'b0, CFG_RESET, 1'b0, 1, 1'b1, ONE_PIXEL},
    '{1'b1, '{irmag_pkg::OR_MIRROR, 13'd0, 13'd0, 3'd0, 16'd0, 32'hFFFF_FFFF,
              32'hFFFF_FFFC},
      1'b1, 1, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFC, 1'b1, 1'b1}},
    '{1'b1, '{irmag_pkg::OR_ROT90, 13'h1FFF, 13'h1FFF, irmag_pkg::BPP_THREE, 16'hFFFF,
              32'h1000, 32'h2_0000},
      1'b1, 2, 1'b0, NO_WANT},
    '{1'b1, '{irmag_pkg::OR_ROT90_MIR, 13'd2, 13'd2, irmag_pkg::BPP_FOUR, 16'd0,
              32'h40, 32'h8000},
      1'b1, 4, 1'b0, NO_WANT},
    '{1'b1, '{irmag_pkg::OR_ROT180, 13'd3, 13'd1, 3'd7, 16'd12, 32'h100, 32'h200},
      1'b1, 3, 1'b0, NO_WANT},
    '{1'b1, '{irmag_pkg::OR_ROT180_MIR, 13'd1, 13'd3, irmag_pkg::BPP_THREE, 16'd5,
              32'hFFFF_FFF0, 32'h300},
      1'b1, 3, 1'b0, NO_WANT},
    '{1'b1, '{irmag_pkg::OR_ROT270, 13'd2, 13'd2, irmag_pkg::BPP_FOUR, 16'd8, 32'h0,
              32'hFFFF_FF00},
      1'b1, 2, 1'b0, NO_WANT},
    '{1'b1, '{irmag_pkg::OR_ROT270_MIR, 13'd2, 13'd1, irmag_pkg::BPP_FOUR, 16'd8, 32'h0,
              32'h1000},
      1'b0, 2, 1'b0, NO_WANT},
    '{1'b1, '{irmag_pkg::OR_IDENT, 13'd4, 13'd2, irmag_pkg::BPP_THREE, 16'd20, 32'h100,
              32'h5000},
      1'b0, 3, 1'b0, NO_WANT}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                restart_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ADDR_W-1:0]   source_address_o;
  logic [ADDR_W-1:0]   destination_address_o;
  logic                row_end_o;
  logic                last_pixel_o;

  cfg_set_t    cur_cfg;
  logic [11:0] col_pos;
  logic [11:0] row_pos;
  pix_addr_t   pixel_addr_q[$];
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_req;

  image_rotate_mirror_address_gen_unit u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .restart_i             (restart_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .source_address_o      (source_address_o),
    .destination_address_o (destination_address_o),
    .row_end_o             (row_end_o),
    .last_pixel_o          (last_pixel_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(input logic [DIMREG_W-1:0] v);
    if (v == 0) return 1;
    if (v > irmag_pkg::MAX_DIM_DEF) return irmag_pkg::MAX_DIM_DEF;
    return v;
  endfunction

  // Expected addresses of the next pixel; advances the raster position.
  function automatic pix_addr_t next_pixel_addr(input bit rs);
    int unsigned w, h, b, x, y, dw, pitch, dc, dr;
    pix_addr_t   res;
    w = clamp_dim(cur_cfg.width);
    h = clamp_dim(cur_cfg.height);
    b = (cur_cfg.bpp == irmag_pkg::BPP_THREE) ? 3 : 4;
    x = col_pos;
    y = row_pos;
    if (rs || x >= w || y >= h) begin
      x = 0;
      y = 0;
    end
    dw = (cur_cfg.orient inside {irmag_pkg::OR_ROT90, irmag_pkg::OR_ROT90_MIR,
                                 irmag_pkg::OR_ROT270, irmag_pkg::OR_ROT270_MIR}) ? h : w;
    pitch = (dw * b + irmag_pkg::PITCH_ALIGN_DEF - 1) / irmag_pkg::PITCH_ALIGN_DEF
            * irmag_pkg::PITCH_ALIGN_DEF;
    case (cur_cfg.orient)
      irmag_pkg::OR_MIRROR: begin
        dc = w - 1 - x;  dr = y;
      end
      irmag_pkg::OR_ROT90: begin
        dc = h - 1 - y;  dr = x;
      end
      irmag_pkg::OR_ROT90_MIR: begin
        dc = h - 1 - y;  dr = w - 1 - x;
      end
      irmag_pkg::OR_ROT180: begin
        dc = w - 1 - x;  dr = h - 1 - y;
      end
      irmag_pkg::OR_ROT180_MIR: begin
        dc = x;          dr = h - 1 - y;
      end
      irmag_pkg::OR_ROT270: begin
        dc = y;          dr = w - 1 - x;
      end
      irmag_pkg::OR_ROT270_MIR: begin
        dc = y;          dr = x;
      end
      default: begin
        dc = x;          dr = y;
      end
    endcase
    res.src  = cur_cfg.sbase + y * cur_cfg.spitch + x * b;
    res.dst  = (cur_cfg.orient == irmag_pkg::OR_IDENT) ? res.src :
               cur_cfg.dbase + dr * pitch + dc * b;
    res.rend = (x == w - 1);
    res.last = res.rend && (y == h - 1);
    if (res.last) begin
      col_pos = '0;
      row_pos = '0;
    end else if (res.rend) begin
      col_pos = '0;
      row_pos = 12'(y + 1);
    end else begin
      col_pos = 12'(x + 1);
      row_pos = 12'(y);
    end
    return res;
  endfunction

  function automatic logic [DIMREG_W-1:0] rand_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return DIMREG_W'($urandom_range(1, 8));
    if (r < 87) return '0;
    if (r < 93) return DIMREG_W'($urandom_range(4096, 8191));
    return DIMREG_W'($urandom_range(9, 200));
  endfunction

  function automatic cfg_set_t rand_cfg();
    cfg_set_t    c;
    int unsigned r;
    c.orient = irmag_pkg::orient_e'($urandom_range(7));
    c.width  = rand_dim();
    c.height = rand_dim();
    r = $urandom_range(99);
    c.bpp    = (r < 45) ? irmag_pkg::BPP_THREE : (r < 90) ? irmag_pkg::BPP_FOUR :
               BPP_W'($urandom_range(7));
    r = $urandom_range(99);
    c.spitch = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : SPITCH_W'($urandom_range(1, 2000));
    c.sbase  = ($urandom_range(9) == 0) ? 32'hFFFF_FF00 | $urandom_range(255) : $urandom();
    c.dbase  = ($urandom_range(9) == 0) ? 32'hFFFF_FF00 | $urandom_range(255) : $urandom();
    return c;
  endfunction

  // Leaves psel high; the caller closes the transfer.
  task automatic apb_write(input irmag_pkg::reg_idx_e idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic set_config(input cfg_set_t c);
    apb_write(irmag_pkg::REG_ORIENTATION,  DATA_W'(c.orient));
    apb_write(irmag_pkg::REG_IMAGE_WIDTH,  DATA_W'(c.width));
    apb_write(irmag_pkg::REG_IMAGE_HEIGHT, DATA_W'(c.height));
    apb_write(irmag_pkg::REG_BPP,          DATA_W'(c.bpp));
    apb_write(irmag_pkg::REG_SRC_PITCH,    DATA_W'(c.spitch));
    apb_write(irmag_pkg::REG_SRC_BASE,     c.sbase);
    apb_write(irmag_pkg::REG_DST_BASE,     c.dbase);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic wait_drained();
    while (pixel_addr_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_pixel(input bit rs, input bit typed, input pix_addr_t want);
    pix_addr_t calc;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    do @(posedge clk_i); while (in_stall_o);
    calc = next_pixel_addr(rs);
    pixel_addr_q.push_back(typed ? want : calc);
    @(negedge clk_i);
  endtask

  initial begin : receiver
    int unsigned held;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (held = 0; held < LONG_HOLD; held++) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pix_addr_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_addr_q.size() == 0) begin
        $error("unexpected word: source_address %h", source_address_o);
        mismatch_cnt++;
      end else begin
        want = pixel_addr_q.pop_front();
        if (source_address_o !== want.src) begin
          $error("source_address: expected %h, got %h", want.src, source_address_o);
          mismatch_cnt++;
        end
        if (destination_address_o !== want.dst) begin
          $error("destination_address: expected %h, got %h", want.dst,
                 destination_address_o);
          mismatch_cnt++;
        end
        if (row_end_o !== want.rend) begin
          $error("row_end: expected %b, got %b", want.rend, row_end_o);
          mismatch_cnt++;
        end
        if (last_pixel_o !== want.last) begin
          $error("last_pixel: expected %b, got %b", want.last, last_pixel_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[image_rotate_mirror_address_gen_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int          ri;
    int          phase;
    int unsigned sent;
    int unsigned seg;
    int unsigned n;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    restart_i    = 1'b0;
    hold_req     = 1'b0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    cur_cfg      = CFG_RESET;
    col_pos      = '0;
    row_pos      = '0;
    snd_idle_pct = 21;
    rcv_idle_pct = 70;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (ri = 0; ri < $size(DIR_ROWS); ri++) begin
      if (DIR_ROWS[ri].wr_cfg) begin
        in_valid_i <= 1'b0;
        wait_drained();
        set_config(DIR_ROWS[ri].cfg);
      end
      send_pixel(DIR_ROWS[ri].restart, DIR_ROWS[ri].typed, DIR_ROWS[ri].want);
      repeat (DIR_ROWS[ri].count - 1) send_pixel(1'b0, 1'b0, NO_WANT);
    end

    for (phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 70 : 0;
      rcv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 21 : 0;
      sent = 0;
      seg  = 0;
      while (sent < PHASE_WORDS) begin
        in_valid_i <= 1'b0;
        wait_drained();
        set_config(rand_cfg());
        n = $urandom_range(15, 50);
        // long output back-pressure while words keep coming
        if (phase == 2 && seg == 2) hold_req = 1'b1;
        repeat (n) send_pixel($urandom_range(99) < 4, 1'b0, NO_WANT);
        sent += n;
        seg++;
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[image_rotate_mirror_address_gen_unit] OK");
    end else begin
      $display("[image_rotate_mirror_address_gen_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/irmag_pkg.sv
rtl/irmag_pitch.sv
rtl/image_rotate_mirror_address_gen_unit.sv
dv/tb.sv
